// ===== sv/box_blur_3x3_rgb_macros.svh =====
// Assertion helpers shared by the blur block.
`ifndef BOX_BLUR_3X3_RGB_MACROS_SVH
`define BOX_BLUR_3X3_RGB_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bblur_pkg.sv =====
package bblur_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CH_W         = 8;
  localparam int PIX_W        = 3 * CH_W;
  localparam int SUM_W        = 12;
  localparam int CNT_W        = 4;
  localparam int RECIP_SHIFT  = 20;
  localparam int RECIP_W      = 21;
  localparam int PROD_W       = SUM_W + RECIP_W;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int FIFO_DEPTH   = 8;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [1:0] {
    PH_RECV  = 2'd0,
    PH_DRAIN = 2'd1
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_t;

  // Which of the up to two results an item produces and how to average them.
  typedef struct packed {
    logic       e0;
    logic       e1;
    logic [1:0] lo0;
    logic [1:0] lo1;
    logic       top_ok;
    logic       bot_ok;
    logic       frame_end;
  } emit_ctl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last_of_run;
    logic            last_of_frame;
  } res_t;

  // Scaled reciprocal, ceil(2^20 / n), for every count a window can have.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    unique case (cnt)
      4'd2:    m = 21'd524288;
      4'd3:    m = 21'd349526;
      4'd4:    m = 21'd262144;
      4'd6:    m = 21'd174763;
      4'd9:    m = 21'd116509;
      default: m = 21'd1048576;
    endcase
    return m;
  endfunction

  // Rounded average (sum + n/2) / n through a reciprocal multiply.
  function automatic logic [CH_W-1:0] avg(input logic [SUM_W-1:0] sum,
                                          input logic [CNT_W-1:0] cnt);
    logic [SUM_W-1:0]  biased;
    logic [PROD_W-1:0] prod;
    biased = sum + SUM_W'(cnt >> 1);
    prod   = PROD_W'(biased) * PROD_W'(recip(cnt));
    return prod[RECIP_SHIFT +: CH_W];
  endfunction

endpackage

// ===== sv/bblur_pix_if.sv =====
interface bblur_pix_if;
  import bblur_pkg::*;

  logic            valid;
  logic            ready;
  logic            mode;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, mode, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

// ===== sv/bblur_res_if.sv =====
interface bblur_res_if;
  import bblur_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            last_of_run;
  logic            last_of_frame;

  modport source (output valid, red_out, green_out, blue_out, last_of_run, last_of_frame,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, last_of_run, last_of_frame,
                  output ready);
endinterface

// ===== sv/bblur_cfg_if.sv =====
interface bblur_cfg_if;
  import bblur_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/box_blur_3x3_rgb.sv =====
// Results of an accepted item pass through S1, S2 and S3 and are written to the result queue
// together; a second result of the same item follows the first out of the queue.
// Throughput: one item per clock while in_ch.ready is high, set by the single-pass pipeline and one row-store port.
// in_ch.ready drops only when seven or more accepted results are still undelivered.
// Reset (rst_n low, synchronous): 640x480 frame, positions and window cleared,
// pipeline and result queue emptied. Row stores are not cleared and need no sweep.
`include "box_blur_3x3_rgb_macros.svh"

module box_blur_3x3_rgb (
  input  logic               clk,
  input  logic               rst_n,
  bblur_cfg_if.sink          cfg_ch,
  bblur_pix_if.sink          in_ch,
  bblur_res_if.source        out_ch
);
  import bblur_pkg::*;

  // Pipeline overview:
  //   accept : position logic, row-store read at the current column, middle-row write.
  //   S1     : upper-row write, new column shifted into the 3x3 window.
  //   S2     : per-channel window sums for up to two results.
  //   S3     : rounded division by reciprocal multiply, results pushed to the queue.
  // The pipeline never stalls; the result queue has room reserved for every item in
  // flight, so a stalled output only holds back the input handshake.

  // Configuration and frame position.
  logic [WIDTH_REG_W-1:0]  frame_width_r;
  logic [HEIGHT_REG_W-1:0] frame_height_r;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  phase_t                  phase_r, phase_nxt;

  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [COL_W-1:0]        c0;
  logic                    last_col;
  logic                    cfg_wr;
  logic                    acc;
  logic                    is_pix;
  logic                    is_flush;
  logic                    emit_en;
  emit_ctl_t               ctl;
  logic [1:0]              n_acc;

  // Row stores: upper holds row r-2, middle holds row r-1 for each column.
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  // Stage S1.
  logic             s1_valid_r;
  logic             s1_is_pix_r;
  logic [COL_W-1:0] s1_addr_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [PIX_W-1:0] upper_rd_r;
  logic [PIX_W-1:0] middle_rd_r;
  logic             s1_fwd_r;
  logic [PIX_W-1:0] s1_fwd_data_r;
  emit_ctl_t        s1_ctl_r;
  logic [PIX_W-1:0] up_eff;

  // 3x3 window, index row*3+col, column 2 newest.
  logic [PIX_W-1:0] win_r [9];

  // Stage S2.
  logic             s2_valid_r;
  emit_ctl_t        s2_ctl_r;
  logic [SUM_W-1:0] sum_nxt [2][3];
  logic [CNT_W-1:0] cnt_nxt [2];

  // Stage S3.
  logic             s3_valid_r;
  logic             s3_e0_r;
  logic             s3_e1_r;
  logic             s3_lof_r;
  logic [SUM_W-1:0] s3_sum_r [2][3];
  logic [CNT_W-1:0] s3_cnt_r [2];
  res_t             res0;
  res_t             res1;
  logic [1:0]       push_n;

  // Result queue and the count of accepted but undelivered results.
  res_t                  fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] fifo_cnt_r;
  logic [FIFO_CNT_W-1:0] pending_r;
  logic                  pop;

  // ------------------------------------------------------------------------
  // Accept side: effective frame size, column clamp and result planning.
  // ------------------------------------------------------------------------
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WIDTH_REG_W'(1);
    end else if (frame_width_r > WIDTH_REG_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width_r;
    end
    if (frame_height_r == '0) begin
      h_eff = HEIGHT_REG_W'(1);
    end else if (frame_height_r > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_r;
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr = cfg_ch.valid && cfg_ch.ready &&
                  (cfg_ch.index == CFG_FRAME_WIDTH || cfg_ch.index == CFG_FRAME_HEIGHT);

  // Room is kept for the worst case of two results from the next item.
  assign in_ch.ready = (pending_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    c0       = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
    last_col = (WIDTH_REG_W'(c0) + WIDTH_REG_W'(1)) == w_eff;

    // A flush while receiving or a pixel while draining is taken and dropped.
    is_pix   = acc && (phase_r == PH_RECV) && !in_ch.mode;
    is_flush = acc && (phase_r == PH_DRAIN) && in_ch.mode;
    emit_en  = (is_pix && (row_r != '0)) || is_flush;

    // The first result is the pixel to the left; the last column adds itself.
    ctl.e0        = emit_en && (c0 != '0);
    ctl.e1        = emit_en && last_col;
    ctl.lo0       = (c0 >= COL_W'(2)) ? 2'd0 : 2'd1;
    ctl.lo1       = (c0 != '0) ? 2'd1 : 2'd2;
    ctl.top_ok    = is_pix ? (row_r >= ROW_W'(2)) : (h_eff >= HEIGHT_REG_W'(2));
    ctl.bot_ok    = is_pix;
    ctl.frame_end = is_flush;
    n_acc         = 2'(ctl.e0) + 2'(ctl.e1);
  end

  // Frame position sequencer.
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    phase_nxt = phase_r;
    priority if (cfg_wr) begin
      col_nxt   = '0;
      row_nxt   = '0;
      phase_nxt = PH_RECV;
    end else if (is_pix) begin
      if (last_col) begin
        col_nxt = '0;
        if ((HEIGHT_REG_W'(row_r) + HEIGHT_REG_W'(1)) >= h_eff) begin
          row_nxt   = h_eff[ROW_W-1:0];
          phase_nxt = PH_DRAIN;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = c0 + COL_W'(1);
      end
    end else if (is_flush) begin
      if (last_col) begin
        col_nxt   = '0;
        row_nxt   = '0;
        phase_nxt = PH_RECV;
      end else begin
        col_nxt = c0 + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
      col_r          <= '0;
      row_r          <= '0;
      phase_r        <= PH_RECV;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          CFG_FRAME_WIDTH:  frame_width_r  <= cfg_ch.data[WIDTH_REG_W-1:0];
          CFG_FRAME_HEIGHT: frame_height_r <= cfg_ch.data[HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
    end
  end

  // ------------------------------------------------------------------------
  // Row stores. Reads are registered and see the contents before this edge.
  // The middle row is written at accept; the upper row takes the old middle
  // value in the following cycle, so a back-to-back read of the same column (a
  // one-pixel-wide frame) is forwarded around the store.
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (is_pix || is_flush) begin
      middle_rd_r <= middle_mem[c0];
    end
    if (is_pix) begin
      middle_mem[c0] <= {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
    end
  end

  always_ff @(posedge clk) begin
    if (is_pix || is_flush) begin
      upper_rd_r <= upper_mem[c0];
    end
    if (s1_valid_r && s1_is_pix_r) begin
      upper_mem[s1_addr_r] <= middle_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= is_pix || is_flush;
    end
  end

  always_ff @(posedge clk) begin
    s1_is_pix_r   <= is_pix;
    s1_addr_r     <= c0;
    s1_pix_r      <= is_pix ? {in_ch.red_in, in_ch.green_in, in_ch.blue_in} : '0;
    s1_ctl_r      <= ctl;
    s1_fwd_r      <= s1_valid_r && s1_is_pix_r && (s1_addr_r == c0);
    s1_fwd_data_r <= middle_rd_r;
  end

  assign up_eff = s1_fwd_r ? s1_fwd_data_r : upper_rd_r;

  // ------------------------------------------------------------------------
  // S1: shift the new column into the window.
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_valid_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= up_eff;
      win_r[5] <= middle_rd_r;
      win_r[8] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_ctl_r <= s1_ctl_r;
  end

  // ------------------------------------------------------------------------
  // S2: channel sums over the in-frame rows and columns lo..2 of the window.
  // ------------------------------------------------------------------------
  always_comb begin
    logic [1:0] lo;
    logic [1:0] rows;
    rows = 2'd1 + 2'(s2_ctl_r.top_ok) + 2'(s2_ctl_r.bot_ok);
    for (int k = 0; k < 2; k++) begin
      lo = (k == 0) ? s2_ctl_r.lo0 : s2_ctl_r.lo1;
      cnt_nxt[k] = CNT_W'(rows) * CNT_W'(2'd3 - lo);
      for (int ch = 0; ch < 3; ch++) begin
        sum_nxt[k][ch] = '0;
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            if ((r != 0 || s2_ctl_r.top_ok) && (r != 2 || s2_ctl_r.bot_ok) && c >= lo) begin
              sum_nxt[k][ch] = sum_nxt[k][ch] + SUM_W'(win_r[r*3+c][CH_W*(2-ch) +: CH_W]);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_e0_r  <= s2_ctl_r.e0;
    s3_e1_r  <= s2_ctl_r.e1;
    s3_lof_r <= s2_ctl_r.frame_end;
    s3_sum_r <= sum_nxt;
    s3_cnt_r <= cnt_nxt;
  end

  // ------------------------------------------------------------------------
  // S3: rounded averages. Only the last result of an item marks end of run,
  // and only the last result of a drained bottom row marks end of frame.
  // ------------------------------------------------------------------------
  always_comb begin
    res0.red           = avg(s3_sum_r[0][0], s3_cnt_r[0]);
    res0.green         = avg(s3_sum_r[0][1], s3_cnt_r[0]);
    res0.blue          = avg(s3_sum_r[0][2], s3_cnt_r[0]);
    res0.last_of_run   = !s3_e1_r;
    res0.last_of_frame = 1'b0;
    res1.red           = avg(s3_sum_r[1][0], s3_cnt_r[1]);
    res1.green         = avg(s3_sum_r[1][1], s3_cnt_r[1]);
    res1.blue          = avg(s3_sum_r[1][2], s3_cnt_r[1]);
    res1.last_of_run   = 1'b1;
    res1.last_of_frame = s3_lof_r;
    push_n             = s3_valid_r ? (2'(s3_e0_r) + 2'(s3_e1_r)) : 2'd0;
  end

  // ------------------------------------------------------------------------
  // Result queue.
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s3_valid_r) begin
      if (s3_e0_r && s3_e1_r) begin
        fifo_mem_r[wr_ptr_r]                  <= res0;
        fifo_mem_r[wr_ptr_r + FIFO_PTR_W'(1)] <= res1;
      end else if (s3_e0_r) begin
        fifo_mem_r[wr_ptr_r] <= res0;
      end else if (s3_e1_r) begin
        fifo_mem_r[wr_ptr_r] <= res1;
      end
    end
  end

  assign pop = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      pending_r  <= '0;
    end else begin
      wr_ptr_r   <= wr_ptr_r + FIFO_PTR_W'(push_n);
      rd_ptr_r   <= rd_ptr_r + FIFO_PTR_W'(pop);
      fifo_cnt_r <= fifo_cnt_r + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
      pending_r  <= pending_r + FIFO_CNT_W'(n_acc) - FIFO_CNT_W'(pop);
    end
  end

  assign out_ch.valid         = (fifo_cnt_r != '0);
  assign out_ch.red_out       = fifo_mem_r[rd_ptr_r].red;
  assign out_ch.green_out     = fifo_mem_r[rd_ptr_r].green;
  assign out_ch.blue_out      = fifo_mem_r[rd_ptr_r].blue;
  assign out_ch.last_of_run   = fifo_mem_r[rd_ptr_r].last_of_run;
  assign out_ch.last_of_frame = fifo_mem_r[rd_ptr_r].last_of_frame;

  // ------------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------------
  `BB_ASSERT_NOW(a_queue_cap, clk, rst_n, 1'b1, fifo_cnt_r <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
  `BB_ASSERT_NOW(a_queue_vs_pending, clk, rst_n, 1'b1, fifo_cnt_r <= pending_r, "queue holds more than was planned")
  `BB_ASSERT_NOW(a_drain_row, clk, rst_n, phase_r == PH_DRAIN, row_r == h_eff[ROW_W-1:0], "draining off the last row")
  `BB_ASSERT_NEXT(a_cfg_restart, clk, rst_n, cfg_wr, col_r == '0 && row_r == '0 && phase_r == PH_RECV, "register write did not restart the frame")

endmodule
